/* src/rtpp_pkg.sv */
// Shared types and codes of the rigid transform block.
package rtpp_pkg;

    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;

    // Operation selector carried with every request.
    typedef enum logic [CMD_W-1:0] {
        CMD_POINT      = 3'd0,
        CMD_INV_POINT  = 3'd1,
        CMD_ROTATE     = 3'd2,
        CMD_INV_ROTATE = 3'd3,
        CMD_PLANE      = 3'd4,
        CMD_INV_PLANE  = 3'd5
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0 = 3'd0,
        CFG_ROT_ROW1 = 3'd1,
        CFG_ROT_ROW2 = 3'd2,
        CFG_TRANS_X  = 3'd3,
        CFG_TRANS_Y  = 3'd4,
        CFG_TRANS_Z  = 3'd5
    } t_cfg_idx;

    // Decoded operation, handed from the front end to the datapath.
    typedef struct packed {
        logic transpose;  // use R^T instead of R
        logic sub_t;      // subtract T before rotating
        logic add_t;      // add T after rotating
        logic plane;      // distance d + T.n' with the rotated normal
        logic plane_inv;  // distance d - T.n with the source normal
        logic zero;       // unused command: all result fields zero
    } t_op;

endpackage

/* src/rigid_transform_point_plane_core.sv */
// Top level of the rigid transform block: configuration, queue and datapath.
//
// Applies a configured rigid transform (3x3 rotation R in signed Q1.14,
// translation T in signed Q16.16) to one point, vector or plane per clock.
// tuser selects the operation: 0 R*v+T, 1 R^T*(v-T), 2 R*v, 3 R^T*v,
// 4 plane (n' = R*n, d' = d + T.n'), 5 inverse plane (n' = R^T*n,
// d' = d - T.n); codes 6 and 7 return an all-zero result. Every output is
// rounded half up and saturated to the coordinate width; out_distance is
// zero for the vector operations. A request is taken every clock while the
// four-entry request queue has room, and its result reaches the master side
// through the queue and the pipeline. The rate of one request per clock comes
// from nine coefficient multipliers and three translation multipliers that run
// side by side in a six-stage pipe; a stall on the master side freezes that
// pipe and the queue absorbs up to four more requests. Configuration writes
// take effect at once and belong to idle periods; after reset R is the
// identity and T is zero.
module rigid_transform_point_plane_core #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Request side
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // in_x, in_y, in_z, in_distance from bit 0 up, zero padded to bytes
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // command
    input  logic [rtpp_pkg::CMD_W-1:0]            s_axis_tuser,
    // Result side
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_x, out_y, out_z, out_distance from bit 0 up, zero padded to bytes
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [rtpp_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0]
                                                  i_cfg_data
);
    import rtpp_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int KW     = COEF_WIDTH;
    localparam int VW     = CW + 1;
    localparam int ROW_W  = 3 * KW;
    localparam int DATA_W = ((4*CW+7)/8)*8;
    localparam int OP_W   = $bits(t_op);
    localparam int Q_W    = OP_W + 3*VW + 3*CW + CW;

    logic [ROW_W-1:0] r_rot [NUM_AXES];
    logic [3*CW-1:0]  r_trans;

    logic          w_full;
    logic          w_push;
    t_op           w_f_op;
    logic [3*VW-1:0] w_f_vop;
    logic [Q_W-1:0]  w_q_in;
    logic [Q_W-1:0]  w_q_out;
    logic            w_q_valid;
    logic            w_pop;
    logic [CW-1:0]   w_ox, w_oy, w_oz, w_od;

    // Configuration registers; the matrix resets to identity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                r_rot[r] <= ROW_W'(1) << (r*KW + KW - 2);
            end
            r_trans <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ROT_ROW0: r_rot[0] <= i_cfg_data[ROW_W-1:0];
                CFG_ROT_ROW1: r_rot[1] <= i_cfg_data[ROW_W-1:0];
                CFG_ROT_ROW2: r_rot[2] <= i_cfg_data[ROW_W-1:0];
                CFG_TRANS_X:  r_trans[0*CW +: CW] <= i_cfg_data[CW-1:0];
                CFG_TRANS_Y:  r_trans[1*CW +: CW] <= i_cfg_data[CW-1:0];
                CFG_TRANS_Z:  r_trans[2*CW +: CW] <= i_cfg_data[CW-1:0];
                default: begin
                    // drop writes to undefined indexes
                end
            endcase
        end
    end

    // Decode the request and form the operand vector.
    rtpp_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_vec   (s_axis_tdata[3*CW-1:0]),
        .i_trans (r_trans),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_op    (w_f_op),
        .o_vop   (w_f_vop)
    );

    // Queue entry: distance, source vector, operand vector, operation.
    assign w_q_in = {s_axis_tdata[4*CW-1:3*CW], s_axis_tdata[3*CW-1:0], w_f_vop, w_f_op};

    rtpp_queue #(
        .WIDTH (Q_W),
        .AW    (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_q_out)
    );

    rtpp_back #(
        .COORD_WIDTH (CW),
        .COEF_WIDTH  (KW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .i_op    (t_op'(w_q_out[OP_W-1:0])),
        .i_vop   (w_q_out[OP_W +: 3*VW]),
        .i_vin   (w_q_out[OP_W + 3*VW +: 3*CW]),
        .i_dist  (w_q_out[OP_W + 3*VW + 3*CW +: CW]),
        .i_rot   (r_rot),
        .i_trans (r_trans),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_z     (w_oz),
        .o_dist  (w_od)
    );

    assign m_axis_tdata = DATA_W'({w_od, w_oz, w_oy, w_ox});

endmodule

/* src/rtpp_front.sv */
// Front end: decode the command and form the operand vector.
module rtpp_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rtpp_pkg::CMD_W-1:0]    i_cmd,
    input  logic [3*COORD_WIDTH-1:0]      i_vec,    // x, y, z from bit 0 up
    input  logic [3*COORD_WIDTH-1:0]      i_trans,  // x, y, z from bit 0 up
    input  logic                          i_full,
    output logic                          o_push,
    output rtpp_pkg::t_op                 o_op,
    output logic [3*(COORD_WIDTH+1)-1:0]  o_vop     // x, y, z from bit 0 up
);
    import rtpp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int VW = CW + 1;

    t_op w_op;
    logic signed [VW-1:0] w_v [NUM_AXES];
    logic signed [VW-1:0] w_t [NUM_AXES];

    always_comb begin
        w_op = '0;
        unique case (i_cmd)
            CMD_POINT: begin
                w_op.add_t = 1'b1;
            end
            CMD_INV_POINT: begin
                w_op.transpose = 1'b1;
                w_op.sub_t     = 1'b1;
            end
            CMD_ROTATE: begin
                w_op.transpose = 1'b0;
            end
            CMD_INV_ROTATE: begin
                w_op.transpose = 1'b1;
            end
            CMD_PLANE: begin
                w_op.plane = 1'b1;
            end
            CMD_INV_PLANE: begin
                w_op.transpose = 1'b1;
                w_op.plane_inv = 1'b1;
            end
            default: begin
                w_op.zero = 1'b1;
            end
        endcase
    end

    // Form v - T exactly at one extra bit for the inverse point transform.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_v[a] = VW'($signed(i_vec[a*CW +: CW]));
            w_t[a] = w_op.sub_t ? VW'($signed(i_trans[a*CW +: CW])) : '0;
            o_vop[a*VW +: VW] = w_v[a] - w_t[a];
        end
    end

    assign o_op    = w_op;
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

/* src/rtpp_queue.sv */
// Short request queue between the front end and the datapath.
module rtpp_queue #(
    parameter int WIDTH = 8,
    parameter int AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = 1 << AW;
    localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != DEPTH_C))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

/* src/rtpp_back.sv */
// Datapath: matrix products, rounding, plane distance and output register.
module rtpp_back #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  rtpp_pkg::t_op                 i_op,
    input  logic [3*(COORD_WIDTH+1)-1:0]  i_vop,
    input  logic [3*COORD_WIDTH-1:0]      i_vin,
    input  logic [COORD_WIDTH-1:0]        i_dist,
    input  logic [3*COEF_WIDTH-1:0]       i_rot [3],
    input  logic [3*COORD_WIDTH-1:0]      i_trans,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_WIDTH-1:0]        o_x,
    output logic [COORD_WIDTH-1:0]        o_y,
    output logic [COORD_WIDTH-1:0]        o_z,
    output logic [COORD_WIDTH-1:0]        o_dist
);
    import rtpp_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int KW     = COEF_WIDTH;
    localparam int VW     = CW + 1;
    localparam int PW     = KW + VW;
    localparam int FRAC_C = KW - 2;
    localparam int FRAC_V = CW / 2;
    localparam int ACC_W  = PW + 2;
    localparam int SH_W   = ACC_W - FRAC_C;
    localparam int DP_W   = 2 * CW;
    localparam int DS_W   = DP_W + 2;
    localparam int DT_W   = DS_W - FRAC_V;
    localparam int DD_W   = DT_W + 1;

    localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(1) << (FRAC_C - 1);
    localparam logic signed [DS_W-1:0]  HALF_V = DS_W'(1) << (FRAC_V - 1);
    localparam logic [CW-1:0] S_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] S_MIN = {1'b1, {(CW-1){1'b0}}};

    logic       w_adv;
    logic [4:0] r_vld;
    logic       r_out_valid;

    // Stage 1: nine coefficient products
    logic signed [KW-1:0] w_coef [NUM_AXES][NUM_AXES];
    logic signed [VW-1:0] w_vop  [NUM_AXES];
    logic signed [PW-1:0] r1_prod [NUM_AXES][NUM_AXES];
    logic signed [CW-1:0] r1_tadd [NUM_AXES];
    logic [3*CW-1:0] r1_v, r2_v, r3_v;
    logic [CW-1:0]   r1_d, r2_d, r3_d, r4_d, r5_d;
    t_op             r1_op, r2_op, r3_op, r4_op, r5_op;

    // Stage 2: row sums
    logic signed [ACC_W-1:0] w_acc  [NUM_AXES];
    logic signed [ACC_W-1:0] r2_acc [NUM_AXES];

    // Stage 3: round and saturate the rotated vector
    logic [SH_W-1:0] w_q   [NUM_AXES];
    logic [CW-1:0]   w_res [NUM_AXES];
    logic [CW-1:0]   r3_res [NUM_AXES];
    logic [CW-1:0]   r4_res [NUM_AXES];
    logic [CW-1:0]   r5_res [NUM_AXES];

    // Stage 4 and 5: translation dot product
    logic [CW-1:0]          w_n   [NUM_AXES];
    logic signed [DP_W-1:0] r4_dp [NUM_AXES];
    logic signed [DS_W-1:0] r5_dsum;

    // Stage 6: distance and output register
    logic signed [DT_W-1:0] w_dot;
    logic signed [DD_W-1:0] w_dext;
    logic signed [DD_W-1:0] w_dfull;
    logic [CW-1:0]          w_dsat;
    logic [CW-1:0]          r_out [NUM_AXES];
    logic [CW-1:0]          r_out_dist;

    // The whole pipe advances together; hold everything while the output waits.
    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = i_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[3:0], i_valid};
            r_out_valid <= r_vld[4];
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            w_vop[r] = $signed(i_vop[r*VW +: VW]);
            for (int c = 0; c < NUM_AXES; c++) begin
                w_coef[r][c] = i_op.transpose ? $signed(i_rot[c][r*KW +: KW])
                                              : $signed(i_rot[r][c*KW +: KW]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            w_acc[r] = ACC_W'(r1_prod[r][0]) + ACC_W'(r1_prod[r][1])
                     + ACC_W'(r1_prod[r][2]) + (ACC_W'(r1_tadd[r]) <<< FRAC_C)
                     + HALF_C;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_AXES; r++) begin
            w_q[r] = r2_acc[r][ACC_W-1:FRAC_C];
            if (w_q[r][SH_W-1:CW-1] == '0 || w_q[r][SH_W-1:CW-1] == '1) begin
                w_res[r] = w_q[r][CW-1:0];
            end else begin
                w_res[r] = w_q[r][SH_W-1] ? S_MIN : S_MAX;
            end
            w_n[r] = r3_op.plane_inv ? r3_v[r*CW +: CW] : r3_res[r];
        end
    end

    always_comb begin
        w_dot   = r5_dsum[DS_W-1:FRAC_V];
        w_dext  = DD_W'($signed(r5_d));
        w_dfull = r5_op.plane_inv ? (w_dext - DD_W'(w_dot)) : (w_dext + DD_W'(w_dot));
        if (w_dfull[DD_W-1:CW-1] == '0 || w_dfull[DD_W-1:CW-1] == '1) begin
            w_dsat = w_dfull[CW-1:0];
        end else begin
            w_dsat = w_dfull[DD_W-1] ? S_MIN : S_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                for (int c = 0; c < NUM_AXES; c++) begin
                    r1_prod[r][c] <= w_coef[r][c] * w_vop[c];
                end
                r1_tadd[r] <= i_op.add_t ? $signed(i_trans[r*CW +: CW]) : '0;
                r2_acc[r]  <= w_acc[r];
                r3_res[r]  <= w_res[r];
                r4_dp[r]   <= $signed(i_trans[r*CW +: CW]) * $signed(w_n[r]);
                r4_res[r]  <= r3_res[r];
                r5_res[r]  <= r4_res[r];
                r_out[r]   <= r5_op.zero ? '0 : r5_res[r];
            end
            r1_v  <= i_vin;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r1_d  <= i_dist;
            r2_d  <= r1_d;
            r3_d  <= r2_d;
            r4_d  <= r3_d;
            r5_d  <= r4_d;
            r1_op <= i_op;
            r2_op <= r1_op;
            r3_op <= r2_op;
            r4_op <= r3_op;
            r5_op <= r4_op;
            r5_dsum <= DS_W'(r4_dp[0]) + DS_W'(r4_dp[1]) + DS_W'(r4_dp[2]) + HALF_V;
            r_out_dist <= (r5_op.plane || r5_op.plane_inv) ? w_dsat : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_out[0];
    assign o_y     = r_out[1];
    assign o_z     = r_out[2];
    assign o_dist  = r_out_dist;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_vld == $past(r_vld)))
        else $error("pipeline valid bits moved during a stall");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[4]) |=> r_out_valid)
        else $error("request in last stage did not reach the output register");

endmodule

/* sim/rigid_transform_point_plane_core_tb.sv */
// Self-checking stream testbench for the rigid transform core.
`timescale 1ns / 100ps

module rigid_transform_point_plane_core_tb;

    import rtpp_pkg::*;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = COEF_W - 2;
    localparam int COORD_FRAC = COORD_W / 2;
    localparam int DATA_W     = ((4 * COORD_W + 7) / 8) * 8;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int CFG_W      = (ROW_W > COORD_W) ? ROW_W : COORD_W;

    // Codes the package leaves unnamed: both must give an all-zero result.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_W'(CMD_INV_PLANE) + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = CMD_W'(CMD_INV_PLANE) + 2'd2;
    // Register indexes past the last register: the block drops such writes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_TRANS_Z) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(CFG_TRANS_Z) + 2'd2;

    // Slack for the pipe to settle after the last result is taken.
    localparam int PIPE_SLACK  = 10;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 200;

    typedef logic signed [79:0] t_acc;

    localparam t_acc COORD_MAX = (t_acc'(1) <<< (COORD_W - 1)) - t_acc'(1);
    localparam t_acc COORD_MIN = -(t_acc'(1) <<< (COORD_W - 1));

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;  // in_x, in_y, in_z, in_distance from bit 0 up
    } t_request;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] distance;
    } t_transformed;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;
    logic [CMD_W-1:0]     s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // Local copy of the transform registers.
    logic [ROW_W-1:0]          rot_row [3];
    logic signed [COORD_W-1:0] trans   [3];

    t_request     requests_q[$];
    t_transformed transformed_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatch_count = 0;

    rigid_transform_point_plane_core #(
        .COORD_WIDTH (COORD_W),
        .COEF_WIDTH  (COEF_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #2_000_000;
        $display("rigid_transform_point_plane_core_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Transform predictor
    // ------------------------------------------------------------------

    function automatic logic signed [COORD_W-1:0] clamp_coord(t_acc val);
        if (val > COORD_MAX) return COORD_MAX[COORD_W-1:0];
        if (val < COORD_MIN) return COORD_MIN[COORD_W-1:0];
        return val[COORD_W-1:0];
    endfunction

    // Drop COEF_FRAC fraction bits, rounding half up, then saturate.
    function automatic logic signed [COORD_W-1:0] round_rotated(t_acc acc);
        return clamp_coord((acc + (t_acc'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
    endfunction

    // T.n at full precision, rounded half up to the coordinate format.
    function automatic t_acc trans_dot(t_acc n0, t_acc n1, t_acc n2);
        t_acc sum;
        sum = t_acc'(trans[0]) * n0 + t_acc'(trans[1]) * n1 + t_acc'(trans[2]) * n2;
        return (sum + (t_acc'(1) <<< (COORD_FRAC - 1))) >>> COORD_FRAC;
    endfunction

    function automatic t_transformed transform_item(logic [CMD_W-1:0] cmd,
                                                    logic [DATA_W-1:0] data);
        t_acc                      m   [3][3];
        t_acc                      src [3];
        t_acc                      acc;
        t_acc                      dist_in;
        logic signed [COORD_W-1:0] nrm [3];
        t_transformed              res;
        bit                        transpose;

        res = '{default: '0};
        if (cmd > CMD_INV_PLANE) return res;

        for (int r = 0; r < 3; r++) begin
            src[r] = $signed(data[r*COORD_W +: COORD_W]);
            for (int c = 0; c < 3; c++)
                m[r][c] = $signed(rot_row[r][c*COEF_W +: COEF_W]);
        end
        dist_in = $signed(data[3*COORD_W +: COORD_W]);

        transpose = (cmd == CMD_INV_POINT) || (cmd == CMD_INV_ROTATE) ||
                    (cmd == CMD_INV_PLANE);

        // Inverse point: remove T exactly before rotating back.
        if (cmd == CMD_INV_POINT)
            for (int r = 0; r < 3; r++) src[r] = src[r] - t_acc'(trans[r]);

        for (int r = 0; r < 3; r++) begin
            acc = '0;
            for (int c = 0; c < 3; c++)
                acc = acc + (transpose ? m[c][r] : m[r][c]) * src[c];
            if (cmd == CMD_POINT)
                acc = acc + (t_acc'(trans[r]) <<< COEF_FRAC);
            nrm[r] = round_rotated(acc);
        end

        res.x = nrm[0];
        res.y = nrm[1];
        res.z = nrm[2];
        // Forward plane uses the rotated, saturated normal; inverse uses the source one.
        if (cmd == CMD_PLANE)
            res.distance = clamp_coord(dist_in + trans_dot(nrm[0], nrm[1], nrm[2]));
        else if (cmd == CMD_INV_PLANE)
            res.distance = clamp_coord(dist_in - trans_dot(src[0], src[1], src[2]));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer the oldest queued request, idling at random
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : request_driver
        t_request next_req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            // Predict at the accepting edge; registers only change while idle.
            if (s_axis_tvalid && s_axis_tready)
                transformed_q.push_back(transform_item(s_axis_tuser, s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (requests_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = requests_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_req.cmd;
                    s_axis_tdata  <= next_req.data;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus long holds on request
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_asks) begin
            // Start a long hold so the pipe and the request queue fill up.
            hold_served   <= hold_served + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic flag_mismatch(string what);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic signed [COORD_W-1:0] got,
                               logic signed [COORD_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d (%h) want %0d (%h)",
                                    name, got, got, want, want));
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_transformed want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (transformed_q.size() == 0) begin
                flag_mismatch("result with no request outstanding");
            end else begin
                want = transformed_q.pop_front();
                check_field("out_x", m_axis_tdata[0*COORD_W +: COORD_W], want.x);
                check_field("out_y", m_axis_tdata[1*COORD_W +: COORD_W], want.y);
                check_field("out_z", m_axis_tdata[2*COORD_W +: COORD_W], want.z);
                check_field("out_distance", m_axis_tdata[3*COORD_W +: COORD_W],
                            want.distance);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_request(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                 logic [COORD_W-1:0] d);
        t_request req;
        req.cmd  = cmd;
        req.data = {d, z, y, x};
        requests_q.push_back(req);
    endtask

    // Mix of full-range, small, medium and edge coordinates.
    function automatic logic [COORD_W-1:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) return $urandom();
        if (pick < 70) return $urandom_range(32'h0020_0000) - 32'h0010_0000;
        if (pick < 85) return $urandom_range(32'h2000_0000) - 32'h1000_0000;
        case ($urandom_range(4))
            0:       return {1'b1, {(COORD_W-1){1'b0}}};
            1:       return {1'b0, {(COORD_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return 32'h0001_0000;
        endcase
    endfunction

    task automatic queue_random(int count);
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < count; i++) begin
            // Spare codes now and then; the rest spread over the six operations.
            if ($urandom_range(99) < 6)
                cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            else
                cmd = CMD_W'($urandom_range(CMD_INV_PLANE, CMD_POINT));
            queue_request(cmd, random_coord(), random_coord(), random_coord(),
                          random_coord());
        end
    endtask

    // Write one register and mirror it; spare indexes leave the copy untouched.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        case (idx) inside
            CFG_ROT_ROW0, CFG_ROT_ROW1, CFG_ROT_ROW2:
                rot_row[idx[1:0]] = value[ROW_W-1:0];
            CFG_TRANS_X, CFG_TRANS_Y, CFG_TRANS_Z:
                trans[2'(idx - CFG_TRANS_X)] = value[COORD_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_extreme_transform(logic [COEF_W-1:0] entry,
                                          logic [COORD_W-1:0] tx,
                                          logic [COORD_W-1:0] ty,
                                          logic [COORD_W-1:0] tz);
        write_register(CFG_ROT_ROW0, CFG_W'({3{entry}}));
        write_register(CFG_ROT_ROW1, CFG_W'({3{entry}}));
        write_register(CFG_ROT_ROW2, CFG_W'({3{entry}}));
        // Junk in the unused upper bits of the translation writes.
        write_register(CFG_TRANS_X, {16'hA5C3, tx});
        write_register(CFG_TRANS_Y, {16'h5A3C, ty});
        write_register(CFG_TRANS_Z, {16'hFFFF, tz});
    endtask

    // Near-rotation matrices stay inside +/-1.0; others use any entry.
    task automatic load_random_transform(bit near_rotation);
        logic [ROW_W-1:0]   row;
        logic [COORD_W-1:0] t_val;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
                row[c*COEF_W +: COEF_W] = near_rotation ?
                    COEF_W'($urandom_range(32768) - 16384) : COEF_W'($urandom());
            write_register(CFG_IDX_W'(CFG_ROT_ROW0 + r), CFG_W'(row));
        end
        for (int r = 0; r < 3; r++) begin
            t_val = near_rotation ? ($urandom_range(32'h0200_0000) - 32'h0100_0000)
                                  : $urandom();
            write_register(CFG_IDX_W'(CFG_TRANS_X + r), {16'($urandom()), t_val});
        end
    endtask

    // Wait until every request is taken and answered, then let the pipe settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (requests_q.size() != 0 || s_axis_tvalid || transformed_q.size() != 0);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        // Reset values: identity rotation, zero translation.
        rot_row[0] = ROW_W'(16384);
        rot_row[1] = ROW_W'(16384) << COEF_W;
        rot_row[2] = ROW_W'(16384) << (2 * COEF_W);
        for (int r = 0; r < 3; r++) trans[r] = '0;

        // Sender idles a third of the time, receiver over half.
        send_idle_pct = 34;
        recv_idle_pct = 56;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every code, including the spare ones, at the coordinate extremes.
        for (int op = CMD_POINT; op <= CMD_SPARE_HI; op++) begin
            queue_request(CMD_W'(op), 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF);
            queue_request(CMD_W'(op), 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                          32'h8000_0000);
        end
        // Plain values through each operation: 1.0, -2.5, 3.25, d = 10.0.
        for (int op = CMD_POINT; op <= CMD_INV_PLANE; op++)
            queue_request(CMD_W'(op), 32'h0001_0000, 32'hFFFD_8000, 32'h0003_4000,
                          32'h000A_0000);
        wait_drained();
        queue_random(100);
        wait_drained();

        // Most negative entries, translation at its limits, spare index writes.
        load_extreme_transform(16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        write_register(CFG_SPARE_LO, '1);
        write_register(CFG_SPARE_HI, '0);
        queue_random(120);
        wait_drained();

        // Swap the idle pattern: receiver eager, sender sluggish.
        send_idle_pct = 56;
        recv_idle_pct = 34;
        load_extreme_transform(16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_random(120);
        wait_drained();

        load_random_transform(1'b1);
        queue_random(150);
        wait_drained();

        // No idling: sender streams while the receiver holds off for a while.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random_transform(1'b1);
        queue_random(150);
        hold_asks = hold_asks + 1;
        wait_drained();

        load_random_transform(1'b1);
        queue_random(100);
        wait_drained();

        load_random_transform(1'b0);
        queue_random(100);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("rigid_transform_point_plane_core_tb passed");
        end else begin
            $display("rigid_transform_point_plane_core_tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/rtpp_pkg.sv
src/rtpp_front.sv
src/rtpp_queue.sv
src/rtpp_back.sv
src/rigid_transform_point_plane_core.sv
sim/rigid_transform_point_plane_core_tb.sv
